// ===== rtl/int_to_pow2_radix_string_macros.svh =====
`ifndef INT_TO_POW2_RADIX_STRING_MACROS_SVH
`define INT_TO_POW2_RADIX_STRING_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ITPR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ITPR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/itpr_pkg.sv =====
package itpr_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NONE  = 8'h00;
   localparam logic [4:0] DIGIT_TEN  = 5'd10;

   // exponents 1..5 allowed, radix 2..32
   localparam logic [5:0] BASE_EXP_MASK = 6'b111110;

   localparam logic [1:0] EMIT_ERR   = 2'd0;
   localparam logic [1:0] EMIT_MINUS = 2'd1;
   localparam logic [1:0] EMIT_DIGIT = 2'd2;

   typedef struct packed {
      logic       load_in;
      logic       setup;
      logic       step;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic base_ok;
      logic neg;
      logic digit_zero;
      logic last_pos;
      logic out_free;
   } dp_sts_type;

   // log2 of the radix, 0 when the radix is not an allowed power of two
   function automatic logic [2:0] base_shift(input logic [7:0] radix);
      logic [2:0] k;
      k = 3'd0;
      case (radix)
         8'd2:    k = 3'd1;
         8'd4:    k = 3'd2;
         8'd8:    k = 3'd3;
         8'd16:   k = 3'd4;
         8'd32:   k = 3'd5;
         default: k = 3'd0;
      endcase
      if (!BASE_EXP_MASK[k]) begin
         k = 3'd0;
      end
      return k;
   endfunction

   function automatic logic [7:0] digit_char(input logic [4:0] d);
      logic [7:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_A + {3'b000, d} - {3'b000, DIGIT_TEN};
      end
      return c;
   endfunction

endpackage

// ===== rtl/itpr_dp.sv =====
module itpr_dp #(
   parameter int DATA_WIDTH = itpr_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic [7:0]                   req_radix,
   input  itpr_pkg::dp_cmd_type         cmd,
   output itpr_pkg::dp_sts_type         sts,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_ascii_char,
   output logic                         rsp_is_last,
   output logic                         rsp_status
);
   import itpr_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int AW = W + 4;
   localparam int CW = $clog2(W + 1);

   // digit positions and top padding per digit width
   localparam int ND1 = W;
   localparam int ND2 = (W + 1) / 2;
   localparam int ND3 = (W + 2) / 3;
   localparam int ND4 = (W + 3) / 4;
   localparam int ND5 = (W + 4) / 5;
   localparam int PAD2 = ND2 * 2 - W;
   localparam int PAD3 = ND3 * 3 - W;
   localparam int PAD4 = ND4 * 4 - W;
   localparam int PAD5 = ND5 * 5 - W;

   logic [W-1:0]  val_ff, val_in;
   logic [7:0]    radix_ff, radix_in;
   logic [2:0]    sh_ff, sh_in;
   logic [AW-1:0] aln_ff, aln_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_status_ff, rsp_status_in;

   logic [2:0]    sh_new;
   logic [W-1:0]  mag;
   logic [2:0]    pad;
   logic [CW-1:0] nd;
   logic [4:0]    digit;
   logic          out_free;

   assign sh_new   = base_shift(radix_ff);
   assign mag      = val_ff[W-1] ? (~val_ff + 1'b1) : val_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (sh_new)
         3'd2:    begin pad = 3'(PAD2); nd = CW'(ND2); end
         3'd3:    begin pad = 3'(PAD3); nd = CW'(ND3); end
         3'd4:    begin pad = 3'(PAD4); nd = CW'(ND4); end
         3'd5:    begin pad = 3'(PAD5); nd = CW'(ND5); end
         default: begin pad = 3'd0;     nd = CW'(ND1); end
      endcase
   end

   // top digit of the aligned magnitude
   always_comb begin
      unique case (sh_ff)
         3'd2:    digit = {3'b000, aln_ff[AW-1 -: 2]};
         3'd3:    digit = {2'b00, aln_ff[AW-1 -: 3]};
         3'd4:    digit = {1'b0, aln_ff[AW-1 -: 4]};
         3'd5:    digit = aln_ff[AW-1 -: 5];
         default: digit = {4'b0000, aln_ff[AW-1]};
      endcase
   end

   always_comb begin
      val_in   = val_ff;
      radix_in = radix_ff;
      sh_in    = sh_ff;
      aln_in   = aln_ff;
      cnt_in   = cnt_ff;
      if (cmd.load_in) begin
         val_in   = req_value;
         radix_in = req_radix;
      end
      if (cmd.setup) begin
         sh_in  = sh_new;
         // place the padded digit field at the top of the shifter
         aln_in = {4'b0000, mag} << (3'd4 - pad);
         cnt_in = nd;
      end
      if (cmd.step) begin
         aln_in = aln_ff << sh_ff;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.emit_last;
         case (cmd.emit_kind)
            EMIT_MINUS: begin
               rsp_char_in   = CHAR_MINUS;
               rsp_status_in = 1'b0;
            end
            EMIT_DIGIT: begin
               rsp_char_in   = digit_char(digit);
               rsp_status_in = 1'b0;
            end
            default: begin
               rsp_char_in   = CHAR_NONE;
               rsp_status_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      radix_ff      <= radix_in;
      sh_ff         <= sh_in;
      aln_ff        <= aln_in;
      cnt_ff        <= cnt_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.base_ok    = (sh_new != 3'd0);
   assign sts.neg        = val_ff[W-1];
   assign sts.digit_zero = (digit == 5'd0);
   assign sts.last_pos   = (cnt_ff == CW'(1));
   assign sts.out_free   = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== rtl/itpr_ctrl.sv =====
`include "int_to_pow2_radix_string_macros.svh"

module itpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  itpr_pkg::dp_sts_type sts,
   output itpr_pkg::dp_cmd_type cmd
);
   import itpr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_DIGIT = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       started_ff, started_in;

   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      req_ready     = 1'b0;
      cmd.load_in   = 1'b0;
      cmd.setup     = 1'b0;
      cmd.step      = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_kind = EMIT_ERR;
      cmd.emit_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup  = 1'b1;
            started_in = 1'b0;
            if (!sts.base_ok) begin
               state_in = ST_ERR;
            end else if (sts.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_ERR;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_MINUS;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (started_ff || !sts.digit_zero || sts.last_pos) begin
               if (sts.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EMIT_DIGIT;
                  cmd.emit_last = sts.last_pos;
                  cmd.step      = 1'b1;
                  started_in    = 1'b1;
                  if (sts.last_pos) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               // drop a leading zero digit without output
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      started_ff <= started_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ITPR_ASSERT(a_emit_needs_room, cmd.emit |-> sts.out_free, "emit into a full output")
   `ITPR_ASSERT(a_accept_to_setup, (req_valid && req_ready) |=> (state_ff == ST_SETUP), "no setup")
   `ITPR_ASSERT(a_bad_base_err, (cmd.setup && !sts.base_ok) |=> (state_ff == ST_ERR), "base error")
   `ITPR_ASSERT(a_last_ends, (cmd.emit && cmd.emit_last) |=> (state_ff == ST_IDLE), "no end")

endmodule

// ===== rtl/int_to_pow2_radix_string.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_value, req_radix
// rsp      out        rsp_valid/rsp_ready  rsp_ascii_char, rsp_is_last, rsp_status
//
// One request at a time: an accept state, a setup state, then a '-' for a negative
// value and a scan of ceil(DATA_WIDTH / log2(radix)) digit positions; an invalid
// base goes from setup to a single error character. The digit shifter and its
// position counter walk the digits; leading zero digits are scanned without
// output. Reset clears the controller state and the output valid.
// A stalled rsp holds the output register and the scan waits behind it.
module int_to_pow2_radix_string #(
   parameter int DATA_WIDTH = itpr_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic [7:0]                   req_radix,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_ascii_char,
   output logic                         rsp_is_last,
   output logic                         rsp_status
);
   import itpr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   itpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   itpr_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_is_last    (rsp_is_last),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== bench/radix_string_checker.sv =====
`timescale 1ns / 1ps

module radix_string_checker #(
   parameter int DW = itpr_pkg::DATA_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  logic [DW-1:0] req_value,
   input  logic [7:0]    req_radix,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic [7:0]    rsp_ascii_char,
   input  logic          rsp_is_last,
   input  logic          rsp_status,
   output int            mismatch_count,
   output int            pending_count
);

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_BASE = 1'b1;
   localparam logic [4:0] DECIMAL_DIGITS = 5'd10;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       status;
   } char_result_type;

   char_result_type expected_chars[$];

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic push_char(input logic [7:0] ch, input logic last, input logic status);
      char_result_type entry;
      entry.ch     = ch;
      entry.last   = last;
      entry.status = status;
      expected_chars.push_back(entry);
   endtask

   function automatic logic [7:0] ascii_of_digit(input logic [4:0] d);
      if (d < DECIMAL_DIGITS) begin
         return itpr_pkg::CHAR_ZERO + {3'b000, d};
      end
      return itpr_pkg::CHAR_A + {3'b000, d} - {3'b000, DECIMAL_DIGITS};
   endfunction

   // Queue every character that one conversion request produces.
   task automatic predict_conversion(input logic [DW-1:0] value, input logic [7:0] radix);
      logic [DW-1:0] magnitude;
      logic [4:0]    digits [DW+1];
      logic [4:0]    digit_mask;
      logic          negative;
      int            shift;
      int            ndig;
      int            i;
      case (radix)
         8'd2:    shift = 1;
         8'd4:    shift = 2;
         8'd8:    shift = 3;
         8'd16:   shift = 4;
         8'd32:   shift = 5;
         default: shift = 0;
      endcase
      if (shift == 0) begin
         push_char(itpr_pkg::CHAR_NONE, 1'b1, STATUS_BAD_BASE);
         return;
      end
      if (value == '0) begin
         push_char(itpr_pkg::CHAR_ZERO, 1'b1, STATUS_OK);
         return;
      end
      negative   = value[DW-1];
      // the most negative value wraps to itself, which read unsigned is 2^(DW-1)
      magnitude  = negative ? -value : value;
      digit_mask = 5'((1 << shift) - 1);
      ndig = 0;
      while (magnitude != '0) begin
         digits[ndig] = magnitude[4:0] & digit_mask;
         magnitude    = magnitude >> shift;
         ndig++;
      end
      if (negative) begin
         push_char(itpr_pkg::CHAR_MINUS, 1'b0, STATUS_OK);
      end
      for (i = ndig - 1; i >= 0; i--) begin
         push_char(ascii_of_digit(digits[i]), i == 0, STATUS_OK);
      end
   endtask

   always @(posedge clock) begin : watch
      char_result_type oldest;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("character with no request pending", 0, rsp_ascii_char);
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_ascii_char !== oldest.ch) begin
                  report_mismatch("ascii_char", oldest.ch, rsp_ascii_char);
               end
               if (rsp_is_last !== oldest.last) begin
                  report_mismatch("is_last", oldest.last, rsp_is_last);
               end
               if (rsp_status !== oldest.status) begin
                  report_mismatch("status", oldest.status, rsp_status);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_conversion(req_value, req_radix);
         end
         pending_count = expected_chars.size();
      end
   end

endmodule

// ===== bench/tb_int_to_pow2_radix_string.sv =====
`timescale 1ns / 1ps

module tb_int_to_pow2_radix_string;

   localparam int DW = itpr_pkg::DATA_WIDTH_DEF;
   localparam int RANDOM_PER_PHASE = 49;
   localparam int SETTLE_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [DW-1:0] req_value;
   logic [7:0]           req_radix;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [7:0]           rsp_ascii_char;
   logic                 rsp_is_last;
   logic                 rsp_status;

   int mismatch_count;
   int pending_count;
   int tx_idle_pct;
   int rx_idle_pct;

   logic [7:0] good_radix [5] = '{8'd2, 8'd4, 8'd8, 8'd16, 8'd32};

   int_to_pow2_radix_string dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_is_last    (rsp_is_last),
      .rsp_status     (rsp_status)
   );

   radix_string_checker #(.DW(DW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_is_last    (rsp_is_last),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("tb_int_to_pow2_radix_string failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Hold the request until it is taken.
   task automatic send_request(input logic [DW-1:0] value, input logic [7:0] radix);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [DW-1:0] pick_value();
      logic [DW-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = $urandom_range(40);
         6:          v = DW'(1) << $urandom_range(DW - 1);
         7:          v = {1'b1, {(DW-1){1'b0}}} + $urandom_range(3);
         8:          v = {1'b0, {(DW-1){1'b1}}} - $urandom_range(3);
         default:    v = DW'($urandom) >> $urandom_range(DW - 1);
      endcase
      if ($urandom_range(3) == 0) begin
         v = -v;
      end
      return v;
   endfunction

   task automatic random_phase(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < 80) begin
            send_request(pick_value(), good_radix[$urandom_range(4)]);
         end else begin
            send_request(pick_value(), 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_value   = '0;
      req_radix   = '0;
      tx_idle_pct = 9;
      rx_idle_pct = 51;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (good_radix[r]) begin
         send_request({1'b1, {(DW-1){1'b0}}}, good_radix[r]);
         send_request({1'b0, {(DW-1){1'b1}}}, good_radix[r]);
         send_request('0, good_radix[r]);
      end
      send_request('1, 8'd16);
      send_request(DW'(1), 8'd2);
      send_request(DW'(12345), 8'd0);
      send_request(DW'(-7), 8'd1);
      send_request(DW'(99), 8'd3);
      send_request(DW'(5), 8'd6);
      send_request('0, 8'd64);
      send_request('1, 8'd128);
      send_request(DW'(42), 8'd255);

      // let the output side empty completely before going on
      wait_drained();
      random_phase(RANDOM_PER_PHASE);

      wait_drained();
      tx_idle_pct = 51;
      rx_idle_pct = 9;
      random_phase(RANDOM_PER_PHASE);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phase(RANDOM_PER_PHASE);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_int_to_pow2_radix_string passed");
      end else begin
         $display("tb_int_to_pow2_radix_string failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/itpr_pkg.sv
rtl/itpr_dp.sv
rtl/itpr_ctrl.sv
rtl/int_to_pow2_radix_string.sv
bench/radix_string_checker.sv
bench/tb_int_to_pow2_radix_string.sv
